/* rtl/cfd_pkg.sv */
// Shared types and constants of the coded audio frame deframer.
// Depends on nothing; cfd_out_reg, the top level and the testbench import it.
package cfd_pkg;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 15;
    localparam int BYTE_W      = 8;
    localparam int BUF_W       = 16;
    localparam int BCNT_W      = 5;
    localparam int CODE_W      = 8;
    localparam int CHAN_W      = 4;
    localparam int SYM_W       = 10;
    localparam int SPF_W       = 11;
    localparam int FRAME_W     = 16;
    localparam int NBYTES_W    = 15;
    localparam int STATUS_W    = 2;
    localparam int TDATA_W     = 40;

    localparam logic [SPF_W-1:0]    SPF_MAX    = 11'd1024;
    localparam logic [NBYTES_W-1:0] NBYTES_MAX = 15'd16384;
    localparam logic [SPF_W-1:0]    SPF_RST    = 11'd16;
    localparam logic [NBYTES_W-1:0] NBYTES_RST = 15'd128;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_BYTES    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_SAMPLE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;

    typedef struct packed {
        logic [FRAME_W-1:0]  frame_number;
        logic [SYM_W-1:0]    symbol_index;
        logic [CHAN_W-1:0]   channel_index;
        logic [CODE_W-1:0]   sample_code;
        logic [STATUS_W-1:0] status;
        logic                last_of_frame;
    } t_result;

endpackage

/* rtl/cfd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module cfd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/cfd_width_store.sv */
// Per-channel sample width store: the width RAM with write forwarding, a mask
// of coded channels and the search for the next coded channel. Uses cfd_ram.
module cfd_width_store #(
    parameter int MAX_CHANNELS = 16,
    parameter int WW = 4,
    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
    localparam int CC_W = $clog2(MAX_CHANNELS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  logic [WW-1:0]    i_wr_data,
    input  logic [IDX_W-1:0] i_rd_addr,
    output logic [WW-1:0]    o_rd_width,
    input  logic [IDX_W-1:0] i_cur,
    input  logic [CC_W-1:0]  i_cc,
    output logic [IDX_W-1:0] o_next,
    output logic             o_next_found,
    output logic [IDX_W-1:0] o_first,
    output logic             o_first_found
);

    logic [MAX_CHANNELS-1:0] r_mask;
    logic [MAX_CHANNELS-1:0] n_mask;
    logic                    r_fwd_hit;
    logic [WW-1:0]           r_fwd_data;
    logic [WW-1:0]           ram_q;

    cfd_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_CHANNELS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr_en),
        .i_waddr (i_wr_addr),
        .i_wdata (i_wr_data),
        .i_raddr (i_rd_addr),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_mask = r_mask;
        if (i_wr_en) begin
            n_mask[i_wr_addr] = (i_wr_data != '0);
        end
    end

    always_comb begin
        o_next        = '0;
        o_next_found  = 1'b0;
        o_first       = '0;
        o_first_found = 1'b0;
        for (int c = MAX_CHANNELS - 1; c >= 0; c--) begin
            if (n_mask[c] && (CC_W'(c) < i_cc)) begin
                o_first       = IDX_W'(c);
                o_first_found = 1'b1;
                if (IDX_W'(c) > i_cur) begin
                    o_next       = IDX_W'(c);
                    o_next_found = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= '0;
            r_fwd_hit <= 1'b0;
        end else begin
            r_mask    <= n_mask;
            r_fwd_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
        r_fwd_data <= i_wr_data;
    end

    assign o_rd_width = r_fwd_hit ? r_fwd_data : ram_q;

endmodule

/* rtl/cfd_out_reg.sv */
// Output register that parts the result channel from the unpacking logic.
// Depends on cfd_pkg for the result type.
module cfd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  cfd_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_valid,
    output cfd_pkg::t_result o_res,
    output logic             o_free
);

    import cfd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* rtl/codec_frame_deframer.sv */
// Top level of the coded audio frame deframer: header parsing, bit unpacking
// and frame control. Depends on cfd_pkg, cfd_width_store and cfd_out_reg.
//
// The input stream carries one byte per transaction. Each frame opens with a
// header of a 16-bit frame id (high byte first), a gain byte and one width
// byte per channel, followed by the configured number of packed data bytes.
// Every result transaction carries one unpacked sample with its channel,
// symbol and frame id, or a status word (short frame, or no coded channels)
// with tlast set; tlast also marks the final sample of a frame.
// A data byte is accepted in the idle state, cut into its samples in the
// unpacking state and closed by a final step; a status result adds the status
// state. Samples leave at one per cycle while the output register is free,
// paced by the width memory read of the next channel, which is issued as the
// current sample is cut. A byte's first result is cut in the unpacking state
// and registered in the output register, which holds a finished result while
// the receiver stalls; unpacking then waits, and the next byte is still taken
// whenever the block is idle. Reset restores the register defaults (16
// channels, 16 symbols, 128 data bytes) and expects a header; a configuration
// write to one of the three registers abandons a frame in progress likewise.
module codec_frame_deframer #(
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_SAMPLE_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [7:0] sample_code, [11:8] channel_index,
                                          // [21:12] symbol_index, [37:22] frame_number
    output logic [1:0]  o_m_axis_tuser,   // [1:0] status
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data
);

    import cfd_pkg::*;

    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CC_W  = $clog2(MAX_CHANNELS + 1);
    localparam int HP_W  = $clog2(MAX_CHANNELS + 3);
    localparam int HPX_W = HP_W + 1;
    localparam int WW    = $clog2(MAX_SAMPLE_BITS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_UNPACK,
        S_STAT
    } t_state;

    t_state                r_state, n_state;
    logic                  r_in_data, n_in_data;
    logic [HP_W-1:0]       r_hpos, n_hpos;
    logic [FRAME_W-1:0]    r_frame, n_frame;
    logic [BUF_W-1:0]      r_buf, n_buf;
    logic [BCNT_W-1:0]     r_bcnt, n_bcnt;
    logic [IDX_W-1:0]      r_ch, n_ch;
    logic [SYM_W-1:0]      r_sym, n_sym;
    logic [NBYTES_W-1:0]   r_bytes, n_bytes;
    logic                  r_done, n_done;
    logic [STATUS_W-1:0]   r_stat, n_stat;
    logic [CC_W-1:0]       r_cc, n_cc;
    logic [SPF_W-1:0]      r_spf, n_spf;
    logic [NBYTES_W-1:0]   r_nbytes, n_nbytes;

    logic                  in_acc;
    logic                  cfg_acc;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [WW-1:0]         wr_data;
    logic [WW-1:0]         width;
    logic [IDX_W-1:0]      nx_ch;
    logic                  nx_found;
    logic [IDX_W-1:0]      first_ch;
    logic                  first_found;
    logic                  out_load;
    logic                  out_free;
    t_result               out_res;
    t_result               m_res;
    logic [BUF_W-1:0]      code_mask;
    logic [SPF_W-1:0]      sym_next;
    logic [4:0]            cfg_cc;
    logic [SPF_W-1:0]      cfg_spf;
    logic [NBYTES_W-1:0]   cfg_nbytes;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_acc         = i_cfg_valid && o_cfg_ready;

    assign cfg_cc     = i_cfg_data[4:0];
    assign cfg_spf    = i_cfg_data[SPF_W-1:0];
    assign cfg_nbytes = i_cfg_data[NBYTES_W-1:0];

    cfd_width_store #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .WW           (WW)
    ) u_widths (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr_en       (wr_en),
        .i_wr_addr     (wr_addr),
        .i_wr_data     (wr_data),
        .i_rd_addr     (n_ch),
        .o_rd_width    (width),
        .i_cur         (r_ch),
        .i_cc          (r_cc),
        .o_next        (nx_ch),
        .o_next_found  (nx_found),
        .o_first       (first_ch),
        .o_first_found (first_found)
    );

    cfd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_res   (out_res),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_res   (m_res),
        .o_free  (out_free)
    );

    assign o_m_axis_tdata = {2'b00, m_res.frame_number, m_res.symbol_index,
                             m_res.channel_index, m_res.sample_code};
    assign o_m_axis_tuser = m_res.status;
    assign o_m_axis_tlast = m_res.last_of_frame;

    assign code_mask = BUF_W'((17'd1 << width) - 17'd1);
    assign sym_next  = SPF_W'(r_sym) + SPF_W'(1);

    always_comb begin
        n_state   = r_state;
        n_in_data = r_in_data;
        n_hpos    = r_hpos;
        n_frame   = r_frame;
        n_buf     = r_buf;
        n_bcnt    = r_bcnt;
        n_ch      = r_ch;
        n_sym     = r_sym;
        n_bytes   = r_bytes;
        n_done    = r_done;
        n_stat    = r_stat;
        n_cc      = r_cc;
        n_spf     = r_spf;
        n_nbytes  = r_nbytes;
        wr_en     = 1'b0;
        wr_addr   = IDX_W'(r_hpos - HP_W'(3));
        wr_data   = (i_s_axis_tdata > BYTE_W'(MAX_SAMPLE_BITS)) ?
                    WW'(MAX_SAMPLE_BITS) : WW'(i_s_axis_tdata);
        out_load  = 1'b0;
        out_res   = '0;
        out_res.frame_number = r_frame;

        case (r_state)
            S_IDLE: begin
                if (in_acc && !r_in_data) begin
                    if (r_hpos == HP_W'(0)) begin
                        n_frame[15:8] = i_s_axis_tdata;
                    end else if (r_hpos == HP_W'(1)) begin
                        n_frame[7:0] = i_s_axis_tdata;
                    end else if (r_hpos != HP_W'(2)) begin
                        wr_en = 1'b1;
                    end
                    if (HPX_W'(r_hpos) >= HPX_W'(r_cc) + HPX_W'(2)) begin
                        n_in_data = 1'b1;
                        n_hpos    = '0;
                        n_buf     = '0;
                        n_bcnt    = '0;
                        n_sym     = '0;
                        n_bytes   = '0;
                        n_done    = 1'b0;
                        n_ch      = first_ch;
                        if (!first_found) begin
                            n_ch    = '0;
                            n_done  = 1'b1;
                            n_stat  = ST_EMPTY;
                            n_state = S_STAT;
                        end
                    end else begin
                        n_hpos = r_hpos + HP_W'(1);
                    end
                end else if (in_acc) begin
                    n_bytes = r_bytes + NBYTES_W'(1);
                    if (!r_done) begin
                        n_buf  = r_buf | BUF_W'({8'd0, i_s_axis_tdata} << r_bcnt);
                        n_bcnt = r_bcnt + BCNT_W'(8);
                    end
                    n_state = S_UNPACK;
                end
            end
            S_UNPACK: begin
                if (!r_done && (r_bcnt >= BCNT_W'(width))) begin
                    if (out_free) begin
                        out_load              = 1'b1;
                        out_res.sample_code   = CODE_W'(r_buf & code_mask);
                        out_res.channel_index = CHAN_W'(r_ch);
                        out_res.symbol_index  = r_sym;
                        out_res.status        = ST_SAMPLE;
                        n_buf                 = r_buf >> width;
                        n_bcnt                = r_bcnt - BCNT_W'(width);
                        if (nx_found) begin
                            n_ch = nx_ch;
                        end else begin
                            n_ch  = first_ch;
                            n_sym = SYM_W'(sym_next);
                            if (sym_next >= r_spf) begin
                                n_done                = 1'b1;
                                out_res.last_of_frame = 1'b1;
                            end
                        end
                    end
                end else if (r_bytes >= r_nbytes) begin
                    if (!r_done) begin
                        n_stat  = ST_SHORT;
                        n_state = S_STAT;
                    end else begin
                        n_state   = S_IDLE;
                        n_in_data = 1'b0;
                        n_hpos    = '0;
                        n_buf     = '0;
                        n_bcnt    = '0;
                        n_ch      = '0;
                        n_sym     = '0;
                        n_bytes   = '0;
                        n_done    = 1'b0;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_STAT: begin
                if (out_free) begin
                    out_load              = 1'b1;
                    out_res.status        = r_stat;
                    out_res.last_of_frame = 1'b1;
                    n_state               = S_IDLE;
                    if (r_stat == ST_SHORT) begin
                        n_in_data = 1'b0;
                        n_hpos    = '0;
                        n_buf     = '0;
                        n_bcnt    = '0;
                        n_ch      = '0;
                        n_sym     = '0;
                        n_bytes   = '0;
                        n_done    = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cfg_acc && (i_cfg_index == REG_CHANNEL_COUNT || i_cfg_index == REG_SYMBOLS ||
                        i_cfg_index == REG_DATA_BYTES)) begin
            case (i_cfg_index)
                REG_CHANNEL_COUNT: begin
                    if (cfg_cc == 5'd0) begin
                        n_cc = CC_W'(1);
                    end else if (int'(cfg_cc) > MAX_CHANNELS) begin
                        n_cc = CC_W'(MAX_CHANNELS);
                    end else begin
                        n_cc = CC_W'(cfg_cc);
                    end
                end
                REG_SYMBOLS: begin
                    if (cfg_spf == '0) begin
                        n_spf = SPF_W'(1);
                    end else if (cfg_spf > SPF_MAX) begin
                        n_spf = SPF_MAX;
                    end else begin
                        n_spf = cfg_spf;
                    end
                end
                default: begin
                    if (cfg_nbytes == '0) begin
                        n_nbytes = NBYTES_W'(1);
                    end else if (cfg_nbytes > NBYTES_MAX) begin
                        n_nbytes = NBYTES_MAX;
                    end else begin
                        n_nbytes = cfg_nbytes;
                    end
                end
            endcase
            n_state   = S_IDLE;
            n_in_data = 1'b0;
            n_hpos    = '0;
            n_buf     = '0;
            n_bcnt    = '0;
            n_ch      = '0;
            n_sym     = '0;
            n_bytes   = '0;
            n_done    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_in_data <= 1'b0;
            r_hpos    <= '0;
            r_frame   <= '0;
            r_bcnt    <= '0;
            r_ch      <= '0;
            r_sym     <= '0;
            r_bytes   <= '0;
            r_done    <= 1'b0;
            r_stat    <= ST_SAMPLE;
            r_cc      <= CC_W'(MAX_CHANNELS);
            r_spf     <= SPF_RST;
            r_nbytes  <= NBYTES_RST;
        end else begin
            r_state   <= n_state;
            r_in_data <= n_in_data;
            r_hpos    <= n_hpos;
            r_frame   <= n_frame;
            r_bcnt    <= n_bcnt;
            r_ch      <= n_ch;
            r_sym     <= n_sym;
            r_bytes   <= n_bytes;
            r_done    <= n_done;
            r_stat    <= n_stat;
            r_cc      <= n_cc;
            r_spf     <= n_spf;
            r_nbytes  <= n_nbytes;
        end
        r_buf <= n_buf;
    end

    a_bcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bcnt < BCNT_W'(BUF_W))
        else $error("Bit count exceeds the bit buffer.");

    a_chan_coded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_data && !r_done) |-> (CC_W'(r_ch) < r_cc))
        else $error("Current channel lies beyond the channel count.");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && out_res.status != ST_SAMPLE) |-> out_res.last_of_frame)
        else $error("Status result without end of frame.");

    a_data_unpack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_in_data && !cfg_acc) |=> (r_state == S_UNPACK))
        else $error("Data byte accepted without an unpacking pass.");

    a_no_sample_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_done) |-> (out_res.status != ST_SAMPLE))
        else $error("Sample produced after the frame's samples were complete.");

endmodule

/* dv/codec_frame_deframer_tb.sv */
// Self-checking testbench for codec_frame_deframer: drives framed byte streams
// and register writes, predicts every result and compares it on the output.
// Depends on the cfd_pkg package and the codec_frame_deframer RTL.
`timescale 1ns / 1ps

module testbench;
    import cfd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int WIDTH_MIXED = 0;
    localparam int WIDTH_ZERO = 1;
    localparam int WIDTH_FULL = 2;

    logic        i_clk;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = 8'h00;
    logic        m_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [14:0] cfg_data = 15'd0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [39:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;
    logic        o_cfg_ready;

    codec_frame_deframer uut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    class deframe_scoreboard;
        typedef enum logic {PH_HEADER, PH_DATA} t_phase;

        logic [4:0]  reg_channels;
        logic [10:0] reg_symbols;
        logic [14:0] reg_bytes;
        t_phase      phase;
        int unsigned hdr_pos;
        logic [15:0] frame_id;
        logic [7:0]  gain;
        logic [3:0]  widths [16];
        int unsigned bitbuf;
        int unsigned bitcnt;
        int unsigned chan;
        int unsigned sym;
        int unsigned taken;
        bit          done;
        t_result     pending_results [$];
        int          failures;

        function new();
            reg_channels = 5'd16;
            reg_symbols = SPF_RST;
            reg_bytes = NBYTES_RST;
            frame_id = 16'h0000;
            gain = 8'h00;
            foreach (widths[i]) widths[i] = 4'd0;
            failures = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            phase = PH_HEADER;
            hdr_pos = 0;
            bitbuf = 0;
            bitcnt = 0;
            chan = 0;
            sym = 0;
            taken = 0;
            done = 1'b0;
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned top);
            if (v == 0) return 1;
            return (v > top) ? top : v;
        endfunction

        function int unsigned next_coded(int unsigned start, int unsigned cc);
            for (int unsigned c = start; c < cc && c < 16; c++) begin
                if (widths[c] != 4'd0) return c;
            end
            return cc;
        endfunction

        function void push_result(int unsigned code, int unsigned ch, int unsigned s,
                                  logic [STATUS_W-1:0] st, bit last);
            t_result r;
            r.sample_code = CODE_W'(code);
            r.channel_index = CHAN_W'(ch);
            r.symbol_index = SYM_W'(s);
            r.frame_number = frame_id;
            r.status = st;
            r.last_of_frame = last;
            pending_results.push_back(r);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_CHANNEL_COUNT: reg_channels = val[4:0];
                REG_SYMBOLS:       reg_symbols = val[10:0];
                REG_DATA_BYTES:    reg_bytes = val;
                default:           return;
            endcase
            restart_frame();
        endfunction

        function void take_byte(logic [7:0] b);
            int unsigned cc;
            int unsigned w;
            int unsigned code;
            int unsigned ch;
            int unsigned s;
            int unsigned nx;
            bit last;
            cc = clamp(reg_channels, 16);
            if (phase == PH_HEADER) begin
                case (hdr_pos)
                    0: frame_id = {b, 8'h00};
                    1: frame_id[7:0] = b;
                    2: gain = b;
                    default: begin
                        if (hdr_pos - 3 < 16) widths[hdr_pos - 3] = (b > 8) ? 4'd8 : b[3:0];
                    end
                endcase
                if (hdr_pos >= 2 + cc) begin
                    phase = PH_DATA;
                    hdr_pos = 0;
                    bitbuf = 0;
                    bitcnt = 0;
                    sym = 0;
                    taken = 0;
                    done = 1'b0;
                    chan = next_coded(0, cc);
                    if (chan >= cc) begin
                        chan = 0;
                        done = 1'b1;
                        push_result(0, 0, 0, ST_EMPTY, 1'b1);
                    end
                end else begin
                    hdr_pos++;
                end
                return;
            end
            taken++;
            if (!done) begin
                bitbuf = (bitbuf | (int'(b) << bitcnt)) & 32'hFFFF;
                bitcnt += 8;
                while (!done && chan < cc && bitcnt >= widths[chan]) begin
                    w = widths[chan];
                    code = bitbuf & ((1 << w) - 1);
                    ch = chan;
                    s = sym;
                    last = 1'b0;
                    bitbuf >>= w;
                    bitcnt -= w;
                    nx = next_coded(ch + 1, cc);
                    if (nx >= cc) begin
                        sym++;
                        nx = next_coded(0, cc);
                        if (sym >= clamp(reg_symbols, 1024)) begin
                            done = 1'b1;
                            last = 1'b1;
                        end
                    end
                    chan = (nx < cc) ? nx : 0;
                    push_result(code, ch, s, ST_SAMPLE, last);
                end
            end
            if (taken >= clamp(reg_bytes, 16384)) begin
                if (!done) push_result(0, 0, 0, ST_SHORT, 1'b1);
                restart_frame();
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: code %h ch %0d sym %0d frame %h st %0d last %b",
                             got.sample_code, got.channel_index, got.symbol_index,
                             got.frame_number, got.status, got.last_of_frame);
                return;
            end
            want = pending_results.pop_front();
            if (got.sample_code !== want.sample_code ||
                got.channel_index !== want.channel_index ||
                got.symbol_index !== want.symbol_index ||
                got.frame_number !== want.frame_number ||
                got.status !== want.status ||
                got.last_of_frame !== want.last_of_frame) begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch: expected code %h ch %0d sym %0d frame %h st %0d last %b",
                             want.sample_code, want.channel_index, want.symbol_index,
                             want.frame_number, want.status, want.last_of_frame);
                    $display("          actual   code %h ch %0d sym %0d frame %h st %0d last %b",
                             got.sample_code, got.channel_index, got.symbol_index,
                             got.frame_number, got.status, got.last_of_frame);
                end
            end
        endfunction
    endclass

    deframe_scoreboard sb = new();
    bit steady = 1'b0;
    int unsigned idle_cycles = 0;
    int unsigned bytes_sent = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function int unsigned draw_gap();
        return steady ? 0 : $urandom_range(0, 15);
    endfunction

    function logic [7:0] width_byte(int mode);
        if (mode == WIDTH_ZERO) return 8'd0;
        if (mode == WIDTH_FULL) return 8'($urandom_range(8, 255));
        case ($urandom_range(0, 5))
            0: return 8'($urandom_range(0, 255));
            1: return 8'd0;
            default: return 8'($urandom_range(1, 9));
        endcase
    endfunction

    task automatic send_byte(logic [7:0] b);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.take_byte(b);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic send_frame(int mode, int unsigned data_count);
        int unsigned cc;
        cc = sb.clamp(sb.reg_channels, 16);
        repeat (3) send_byte(8'($urandom_range(0, 255)));
        repeat (cc) send_byte(width_byte(mode));
        repeat (data_count) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic random_write();
        logic [CFG_DATA_W-1:0] val;
        int unsigned pick;
        pick = $urandom_range(0, 7);
        case ($urandom_range(0, 2))
            0: begin
                case (pick)
                    0: val = 15'd0;
                    1: val = 15'($urandom_range(16, 31));
                    default: val = 15'($urandom_range(1, 4));
                endcase
                write_reg(REG_CHANNEL_COUNT, val);
            end
            1: begin
                case (pick)
                    0: val = 15'd0;
                    1: val = 15'd2047;
                    2: val = 15'($urandom_range(0, 32767));
                    default: val = 15'($urandom_range(1, 6));
                endcase
                write_reg(REG_SYMBOLS, val);
            end
            default: begin
                case (pick)
                    0: val = 15'd0;
                    1: val = 15'd32767;
                    2: val = 15'($urandom_range(0, 32767));
                    default: val = 15'($urandom_range(1, 8));
                endcase
                write_reg(REG_DATA_BYTES, val);
            end
        endcase
    endtask

    initial begin : receiver
        int unsigned gap;
        wait (rst_n);
        @(posedge i_clk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_result got;
        if (rst_n && o_m_axis_tvalid && m_ready) begin
            got.sample_code = o_m_axis_tdata[7:0];
            got.channel_index = o_m_axis_tdata[11:8];
            got.symbol_index = o_m_axis_tdata[21:12];
            got.frame_number = o_m_axis_tdata[37:22];
            got.status = o_m_axis_tuser;
            got.last_of_frame = o_m_axis_tlast;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (rst_n) begin
            if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready) ||
                (cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("codec_frame_deframer test failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        bit open;
        int unsigned kind;
        int unsigned nb;
        int unsigned random_end;
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;

        // Zero registers act as one: a frame with no coded channels, then
        // saturating widths of one channel.
        write_reg(REG_CHANNEL_COUNT, 15'd0);
        write_reg(REG_SYMBOLS, 15'd0);
        write_reg(REG_DATA_BYTES, 15'd0);
        send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h00); send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00); send_byte(8'h00); send_byte(8'hFF); send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h12); send_byte(8'h34); send_byte(8'h80); send_byte(8'h09);
        send_byte(8'h5A);

        // A skipped channel, samples ending before the bytes do, and a
        // short frame.
        write_reg(REG_CHANNEL_COUNT, 15'd2);
        write_reg(REG_SYMBOLS, 15'd3);
        write_reg(REG_DATA_BYTES, 15'd2);
        write_reg(REG_UNUSED, 15'h7FFF);
        send_byte(8'hAB); send_byte(8'hCD); send_byte(8'h00); send_byte(8'h01);
        send_byte(8'h00); send_byte(8'hA5); send_byte(8'h00);
        write_reg(REG_SYMBOLS, 15'd4);
        send_byte(8'h00); send_byte(8'h01); send_byte(8'h00); send_byte(8'h08);
        send_byte(8'h08); send_byte(8'h11); send_byte(8'h22);

        // Registers above their range, left in the middle of a frame.
        write_reg(REG_CHANNEL_COUNT, 15'd31);
        write_reg(REG_SYMBOLS, 15'd2047);
        write_reg(REG_DATA_BYTES, 15'd32767);
        send_frame(WIDTH_MIXED, 5);

        open = 1'b1;
        random_end = bytes_sent + 60;
        while (bytes_sent < random_end) begin
            steady = 1'b0;
            repeat ($urandom_range(open ? 1 : 0, 3)) random_write();
            open = 1'b0;
            for (int f = $urandom_range(1, 3); f > 0 && !open && bytes_sent < random_end;
                 f--) begin
                steady = ($urandom_range(0, 4) == 0);
                kind = $urandom_range(0, 9);
                nb = sb.clamp(sb.reg_bytes, 16384);
                if (kind == 0) begin
                    repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
                    open = 1'b1;
                end else if (kind == 1 || nb > 40) begin
                    send_frame(WIDTH_MIXED, $urandom_range(0, (nb > 40) ? 40 : nb - 1));
                    open = 1'b1;
                end else begin
                    send_frame((kind == 2) ? WIDTH_ZERO : WIDTH_MIXED, nb);
                end
                if ($urandom_range(0, 3) == 0) wait_drained();
            end
        end

        // One frame at the top of every register: each data byte yields
        // one eight-bit sample, and the frame is left open.
        steady = 1'b0;
        write_reg(REG_CHANNEL_COUNT, 15'd16);
        write_reg(REG_SYMBOLS, 15'd1024);
        write_reg(REG_DATA_BYTES, 15'd16384);
        send_frame(WIDTH_FULL, 4);

        wait_drained();
        if (sb.failures == 0 && sb.pending_results.size() == 0) begin
            $display("codec_frame_deframer test passed");
        end else begin
            $display("codec_frame_deframer test failed");
        end
        $finish;
    end

endmodule

/* codec_frame_deframer.f */
rtl/cfd_pkg.sv
rtl/cfd_ram.sv
rtl/cfd_width_store.sv
rtl/cfd_out_reg.sv
rtl/codec_frame_deframer.sv
dv/codec_frame_deframer_tb.sv
